// ===== rtl/ray_volume_compositor_assert.svh =====
// Assertion macros used by the checker file.
`ifndef RAY_VOLUME_COMPOSITOR_ASSERT_SVH
`define RAY_VOLUME_COMPOSITOR_ASSERT_SVH

// Generic form: explicit clock and active-low reset.
`define RVC_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rvc assertion failed");

// Short form on the default clock and reset names.
`define RVC_ASSERT(lbl, prop) \
  `RVC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/rvc_pkg.sv =====
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared constants, codes and elaboration-time helpers of the compositor.
// ----------------------------------------------------------------------------
package rvc_pkg;

  localparam int unsigned ExpTableDepth = 256;

  localparam longint unsigned One31 = 64'h8000_0000;
  localparam logic [31:0] One31W    = 32'h8000_0000;
  localparam logic [23:0] One23     = 24'h80_0000;
  localparam logic [47:0] SmallOd   = 48'd429497;
  localparam logic [23:0] StopT     = 24'd838;
  localparam logic [23:0] MinOpacity = 24'd8;
  localparam logic [31:0] Ln2Q32    = 32'd2977044472;
  localparam logic [23:0] LogFloorMag = 24'd4527066;
  localparam logic [31:0] FarReset  = 32'd65536000;

  // action codes
  localparam logic [1:0] ActSample = 2'd0;
  localparam logic [1:0] ActLast   = 2'd1;
  localparam logic [1:0] ActEmpty  = 2'd2;

  // register indexes
  localparam logic RegNear = 1'b0;
  localparam logic RegFar  = 1'b1;

  // exp(-x), x in Q.31, 25-term series; only evaluated at elaboration
  function automatic longint unsigned series_exp(input longint unsigned x);
    longint unsigned term;
    longint sum;
    term = One31;
    sum  = longint'(One31);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * x) >> 31) / 64'(k);
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  localparam longint unsigned ExpOne = series_exp(One31);

endpackage

// ===== rtl/rvc_if.sv =====
// ----------------------------------------------------------------------------
// rvc interfaces
// Valid/ready channels: sample input, result output, register write.
// ----------------------------------------------------------------------------
interface rvc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [23:0] step_len;
  logic [23:0] density;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  modport source(output valid, action, step_len, density, red_in, green_in, blue_in,
                 input ready);
  modport sink(input valid, action, step_len, density, red_in, green_in, blue_in,
               output ready);
endinterface

interface rvc_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        alpha_out;
  logic [23:0]        weight_out;
  logic [23:0]        trans_before;
  logic signed [23:0] log_trans_before;
  logic               ray_done;
  logic [15:0]        red_out;
  logic [15:0]        green_out;
  logic [15:0]        blue_out;
  logic [23:0]        final_trans;
  logic [23:0]        ray_opacity;
  logic [31:0]        ray_depth;
  modport source(output valid, alpha_out, weight_out, trans_before, log_trans_before,
                 ray_done, red_out, green_out, blue_out, final_trans, ray_opacity,
                 ray_depth, input ready);
  modport sink(input valid, alpha_out, weight_out, trans_before, log_trans_before,
               ray_done, red_out, green_out, blue_out, final_trans, ray_opacity,
               ray_depth, output ready);
endinterface

interface rvc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/rvc_div.sv =====
// ----------------------------------------------------------------------------
// rvc_div
// Restoring divider, one quotient bit per cycle, NumW quotient bits per divide.
// ----------------------------------------------------------------------------
module rvc_div #(
  parameter int unsigned NumW = 56,
  parameter int unsigned DenW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
        rem_q  <= '0;
        den_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= fits ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ===== rtl/ray_volume_compositor.sv =====
// ----------------------------------------------------------------------------
// ray_volume_compositor
// Emission-absorption compositing of ray samples on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i  : one sample (or ray end / empty ray) per transfer.
//   out_ch_o : exactly one result per input transfer, in order.
//   cfg_i    : near/far plane writes, always ready; write only between items.
// Timing: a 32x32 multiplier is reused by a step sequencer, one product
//   per cycle while it steps. In a composited sample alpha needs one
//   multiply per whole unit of optical depth, the log of the transmittance
//   20 squarings. A skipped sample goes straight to output. Ending a ray
//   adds a finish step and, above minimum opacity, the 56-bit restoring divide.
// in_ch_i.ready is high only while the sequencer is idle; a new item is
// taken the cycle after the previous result has been transferred.
// Reset: planes return to defaults, ray state to T = 1, no output pending.
// A stalled output simply holds its result and the block stays busy.
// ----------------------------------------------------------------------------
module ray_volume_compositor #(
  parameter int unsigned ExpDepth = rvc_pkg::ExpTableDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  rvc_cfg_if.sink   cfg_i,
  rvc_in_if.sink    in_ch_i,
  rvc_out_if.source out_ch_o
);
  import rvc_pkg::*;

  localparam int unsigned IdxW = $clog2(ExpDepth);
  localparam longint unsigned RDiv = 2 * ExpDepth;

  localparam logic [4:0] S_IDLE = 5'd0,  S_OD   = 5'd1,  S_SQ   = 5'd2,
                         S_SCL  = 5'd3,  S_RR   = 5'd4,  S_TABM = 5'd5,
                         S_EXPM = 5'd6,  S_AFIN = 5'd7,  S_WGT  = 5'd8,
                         S_TRN  = 5'd9,  S_CRED = 5'd10, S_CGRN = 5'd11,
                         S_CBLU = 5'd12, S_DEP1 = 5'd13, S_DEP2 = 5'd14,
                         S_LOGI = 5'd15, S_LOGS = 5'd16, S_LOGM = 5'd17,
                         S_FIN  = 5'd18, S_DIV  = 5'd19, S_OUT  = 5'd20;

  logic [31:0] exp_tab [ExpDepth];
  for (genvar g = 0; g < ExpDepth; g++) begin : g_tab
    assign exp_tab[g] = 32'(series_exp((64'(g) * One31) / 64'(ExpDepth)));
  end

  function automatic logic [23:0] rnd_a31(input logic [31:0] a31);
    logic [32:0] s;
    s = (33'(a31) + 33'd128) >> 8;
    return (s > 33'(One23)) ? One23 : s[23:0];
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    return (s > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [15:0] col_out(input logic [31:0] acc);
    logic [32:0] s;
    s = (33'(acc) + 33'h8000) >> 16;
    return (s > 33'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [4:0] find_msb(input logic [23:0] t);
    logic [4:0] m;
    m = '0;
    for (int i = 0; i < 24; i++) begin
      if (t[i]) m = 5'(i);
    end
    return m;
  endfunction

  // sequencer and item registers
  logic [4:0]  state_q;
  logic [1:0]  act_q;
  logic [23:0] step_q, dens_q;
  logic [15:0] red_q, grn_q, blu_q;
  logic [47:0] od_q;
  logic [IdxW-1:0] idx_q;
  logic [31:0] r_q, er_q, v_q, x_q;
  logic [4:0]  ncnt_q, lcnt_q, msb_q;
  logic [19:0] frac_q;
  logic [56:0] dtmp_q;
  // ray state
  logic [23:0] trans_q;
  logic [31:0] racc_q, gacc_q, bacc_q, cursor_q, near_q, far_q;
  logic [47:0] dacc_q;
  logic        term_q, inray_q;
  // result registers
  logic        ovalid_q, done_q;
  logic [23:0] alpha_q, w_q, tb_q, logv_q, ft_q, op_q;
  logic [15:0] ro_q, go_q, bo_q;
  logic [31:0] depth_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] p;
  logic        in_xfer;
  logic [23:0] op_now;
  logic        div_start, div_done;
  logic [55:0] div_q;

  assign in_xfer = in_ch_i.valid && in_ch_i.ready;
  assign op_now  = One23 - trans_q;
  assign div_start = (state_q == S_FIN) && (op_now > MinOpacity);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_OD:   begin mul_a = 32'(step_q);  mul_b = 32'(dens_q); end
      S_SQ:   begin mul_a = od_q[32:1];   mul_b = od_q[32:1]; end
      S_SCL:  begin mul_a = od_q[31:0];   mul_b = 32'(ExpDepth); end
      S_RR:   begin mul_a = r_q;          mul_b = r_q; end
      S_TABM: begin mul_a = exp_tab[idx_q]; mul_b = er_q; end
      S_EXPM: begin mul_a = v_q;          mul_b = 32'(ExpOne); end
      S_WGT:  begin mul_a = 32'(tb_q);    mul_b = 32'(alpha_q); end
      S_TRN:  begin mul_a = 32'(tb_q);    mul_b = 32'(One23 - alpha_q); end
      S_CRED: begin mul_a = 32'(w_q);     mul_b = 32'(red_q); end
      S_CGRN: begin mul_a = 32'(w_q);     mul_b = 32'(grn_q); end
      S_CBLU: begin mul_a = 32'(w_q);     mul_b = 32'(blu_q); end
      S_DEP1: begin mul_a = 32'(w_q);     mul_b = cursor_q; end
      S_DEP2: begin mul_a = 32'(w_q);     mul_b = 32'(step_q); end
      S_LOGS: begin mul_a = x_q;          mul_b = x_q; end
      S_LOGM: begin mul_a = 32'(25'(23 << 20) - {msb_q, frac_q}); mul_b = Ln2Q32; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign p = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] vc;
    logic [23:0] tnew;
    logic [58:0] dsum;
    logic [51:0] dnew;
    logic [32:0] x1;
    logic [27:0] mag;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q <= '0; step_q <= '0; dens_q <= '0;
      red_q <= '0; grn_q <= '0; blu_q <= '0;
      od_q <= '0; idx_q <= '0; r_q <= '0; er_q <= '0; v_q <= '0; x_q <= '0;
      ncnt_q <= '0; lcnt_q <= '0; msb_q <= '0; frac_q <= '0; dtmp_q <= '0;
      trans_q <= One23;
      racc_q <= '0; gacc_q <= '0; bacc_q <= '0; dacc_q <= '0;
      cursor_q <= '0; near_q <= '0; far_q <= FarReset;
      term_q <= 1'b0; inray_q <= 1'b0;
      ovalid_q <= 1'b0; done_q <= 1'b0;
      alpha_q <= '0; w_q <= '0; tb_q <= '0; logv_q <= '0; ft_q <= '0; op_q <= '0;
      ro_q <= '0; go_q <= '0; bo_q <= '0; depth_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegNear: near_q <= cfg_i.data;
          RegFar:  far_q  <= cfg_i.data;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            act_q  <= in_ch_i.action;
            step_q <= in_ch_i.step_len;
            dens_q <= in_ch_i.density;
            red_q  <= in_ch_i.red_in;
            grn_q  <= in_ch_i.green_in;
            blu_q  <= in_ch_i.blue_in;
            alpha_q <= '0; w_q <= '0; tb_q <= '0; logv_q <= '0;
            done_q <= 1'b0; ro_q <= '0; go_q <= '0; bo_q <= '0;
            ft_q <= '0; op_q <= '0; depth_q <= '0;
            if (in_ch_i.action <= ActLast) begin
              if (!inray_q) begin
                cursor_q <= near_q;
                inray_q  <= 1'b1;
              end
            end
            if (in_ch_i.action <= ActLast && !term_q) begin
              tb_q    <= trans_q;
              state_q <= S_OD;
            end else if (in_ch_i.action != ActSample) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OD: begin
          od_q <= p[47:0];
          if (p[47:0] == '0) begin
            alpha_q <= '0;
            state_q <= S_WGT;
          end else if (p[47:0] < SmallOd) begin
            state_q <= S_SQ;
          end else if (p[47:32] >= 16'd24) begin
            v_q     <= '0;
            state_q <= S_AFIN;
          end else begin
            ncnt_q  <= p[36:32];
            state_q <= S_SCL;
          end
        end
        S_SQ: begin
          alpha_q <= rnd_a31(od_q[32:1] - p[63:32]);
          state_q <= S_WGT;
        end
        S_SCL: begin
          idx_q   <= p[32 +: IdxW];
          r_q     <= 32'(64'(p[31:0]) / RDiv);
          state_q <= S_RR;
        end
        S_RR: begin
          er_q    <= One31W - r_q + p[63:32];
          state_q <= S_TABM;
        end
        S_TABM: begin
          v_q     <= p[62:31];
          state_q <= (ncnt_q == '0) ? S_AFIN : S_EXPM;
        end
        S_EXPM: begin
          v_q    <= p[62:31];
          ncnt_q <= ncnt_q - 1'b1;
          if (ncnt_q == 5'd1) state_q <= S_AFIN;
        end
        S_AFIN: begin
          vc      = (v_q > One31W) ? One31W : v_q;
          alpha_q <= rnd_a31(One31W - vc);
          state_q <= S_WGT;
        end
        S_WGT: begin
          w_q     <= 24'((p + 64'h40_0000) >> 23);
          state_q <= S_TRN;
        end
        S_TRN: begin
          tnew    = 24'((p + 64'h40_0000) >> 23);
          trans_q <= tnew;
          if (tnew <= StopT) term_q <= 1'b1;
          state_q <= S_CRED;
        end
        S_CRED: begin
          racc_q  <= sat_add32(racc_q, (p + 64'd64) >> 7);
          state_q <= S_CGRN;
        end
        S_CGRN: begin
          gacc_q  <= sat_add32(gacc_q, (p + 64'd64) >> 7);
          state_q <= S_CBLU;
        end
        S_CBLU: begin
          bacc_q  <= sat_add32(bacc_q, (p + 64'd64) >> 7);
          state_q <= S_DEP1;
        end
        S_DEP1: begin
          dtmp_q  <= {p[55:0], 1'b0};
          state_q <= S_DEP2;
        end
        S_DEP2: begin
          // midpoint depth: w * (2*cursor + step), rounded by 2^8
          dsum     = 59'(dtmp_q) + 59'(p) + 59'd128;
          dnew     = 52'(dacc_q) + 52'(dsum >> 8);
          dacc_q   <= (dnew > 52'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : dnew[47:0];
          cursor_q <= sat_add32(cursor_q, 64'(step_q));
          state_q  <= S_LOGI;
        end
        S_LOGI: begin
          if (tb_q == '0) begin
            logv_q  <= 24'(25'h100_0000 - 25'(LogFloorMag));
            state_q <= (act_q != ActSample) ? S_FIN : S_OUT;
          end else begin
            msb_q   <= find_msb(tb_q);
            x_q     <= 32'(tb_q) << (5'd30 - find_msb(tb_q));
            frac_q  <= '0;
            lcnt_q  <= 5'd20;
            state_q <= S_LOGS;
          end
        end
        S_LOGS: begin
          // one fraction bit of log2 per squaring
          x1 = p[62:30];
          if (x1 >= 33'h8000_0000) begin
            x_q    <= x1[32:1];
            frac_q <= {frac_q[18:0], 1'b1};
          end else begin
            x_q    <= x1[31:0];
            frac_q <= {frac_q[18:0], 1'b0};
          end
          lcnt_q <= lcnt_q - 1'b1;
          if (lcnt_q == 5'd1) state_q <= S_LOGM;
        end
        S_LOGM: begin
          mag     = 28'((p + 64'h8_0000_0000) >> 36);
          logv_q  <= 24'(29'h100_0000 - 29'(mag));
          state_q <= (act_q != ActSample) ? S_FIN : S_OUT;
        end
        S_FIN: begin
          done_q <= 1'b1;
          ro_q   <= col_out(racc_q);
          go_q   <= col_out(gacc_q);
          bo_q   <= col_out(bacc_q);
          ft_q   <= trans_q;
          op_q   <= op_now;
          if (op_now > MinOpacity) begin
            state_q <= S_DIV;
          end else begin
            depth_q <= far_q;
            state_q <= S_OUT;
          end
          trans_q <= One23;
          racc_q <= '0; gacc_q <= '0; bacc_q <= '0; dacc_q <= '0;
          cursor_q <= near_q;
          term_q <= 1'b0;
          inray_q <= 1'b0;
        end
        S_DIV: begin
          if (div_done) begin
            depth_q <= (div_q[55:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      ovalid_q <= (state_q == S_OUT) ? !out_ch_o.ready :
                  ((state_q == S_IDLE && in_xfer && in_ch_i.action == ActSample && term_q) ||
                   (state_q == S_LOGI && tb_q == '0 && act_q == ActSample) ||
                   (state_q == S_LOGM && act_q == ActSample) ||
                   (state_q == S_FIN && !(op_now > MinOpacity)) ||
                   (state_q == S_DIV && div_done));
    end
  end

  rvc_div #(
    .NumW(56),
    .DenW(24)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (56'({dacc_q, 7'b0}) + 56'(op_now >> 1)),
    .divisor_i  (op_now),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign cfg_i.ready   = 1'b1;
  assign in_ch_i.ready = (state_q == S_IDLE);

  assign out_ch_o.valid            = ovalid_q;
  assign out_ch_o.alpha_out        = alpha_q;
  assign out_ch_o.weight_out       = w_q;
  assign out_ch_o.trans_before     = tb_q;
  assign out_ch_o.log_trans_before = logv_q;
  assign out_ch_o.ray_done         = done_q;
  assign out_ch_o.red_out          = ro_q;
  assign out_ch_o.green_out        = go_q;
  assign out_ch_o.blue_out         = bo_q;
  assign out_ch_o.final_trans      = ft_q;
  assign out_ch_o.ray_opacity      = op_q;
  assign out_ch_o.ray_depth        = depth_q;
endmodule

// ===== rtl/rvc_checker.sv =====
// ----------------------------------------------------------------------------
// rvc_checker
// Port-level checks of the compositor, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_volume_compositor_assert.svh"

module rvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        ray_done_i,
  input logic [15:0] red_out_i,
  input logic [23:0] final_trans_i,
  input logic [31:0] ray_depth_i,
  input logic [23:0] alpha_out_i,
  input logic [23:0] trans_before_i
);
  // result held until transferred
  `RVC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)

  // one item in flight: no new transfer while a result is pending
  `RVC_ASSERT(a_no_overlap, out_valid_i |-> !in_ready_i)

  // sequencer leaves idle right after taking an item
  `RVC_ASSERT(a_busy_after_in, in_valid_i && in_ready_i |=> !in_ready_i)

  // ray fields are zero unless the ray ended
  `RVC_ASSERT_CLK(a_ray_zero, clk_i, rst_ni,
    out_valid_i && !ray_done_i |-> red_out_i == 16'd0 && final_trans_i == 24'd0 &&
    ray_depth_i == 32'd0)

  // fractions never exceed one
  `RVC_ASSERT(a_unit_range,
    out_valid_i |-> alpha_out_i <= 24'h80_0000 && trans_before_i <= 24'h80_0000)
endmodule

bind ray_volume_compositor rvc_checker u_rvc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch_i.valid),
  .in_ready_i     (in_ch_i.ready),
  .out_valid_i    (out_ch_o.valid),
  .out_ready_i    (out_ch_o.ready),
  .ray_done_i     (out_ch_o.ray_done),
  .red_out_i      (out_ch_o.red_out),
  .final_trans_i  (out_ch_o.final_trans),
  .ray_depth_i    (out_ch_o.ray_depth),
  .alpha_out_i    (out_ch_o.alpha_out),
  .trans_before_i (out_ch_o.trans_before)
);
